FILE: rtl/core/ncfal_pkg.sv
`timescale 1ns / 1ps

package ncfal_pkg;

	// request codes on req_type
	typedef enum logic [1:0] {
		REQ_SEND = 2'd0,
		REQ_BYTE = 2'd1,
		REQ_TICK = 2'd2
	} req_t;

	// completion codes on status
	typedef enum logic [1:0] {
		ST_ACK     = 2'd0,
		ST_REJ     = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	// result kinds on out_kind
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// frame ids answered by the partner
	localparam logic [3:0] FID_ACK     = 4'd1;
	localparam logic [3:0] FID_UNKNOWN = 4'd2;

	localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd20;
	localparam logic [7:0] ATTEMPT_SAT      = 8'hFF;
	localparam int         QUEUE_DEPTH      = 4;

	typedef enum logic {
		ACT_SEND   = 1'b0,
		ACT_STATUS = 1'b1
	} act_kind_t;

	// one queued piece of work for the back end
	typedef struct packed {
		act_kind_t  kind;
		logic [7:0] hdr;
		logic [7:0] val;
		status_t    st;
	} action_t;

	function automatic logic [3:0] check_nibble(input logic [3:0] id, input logic [7:0] data);
		logic [3:0] sum;
		sum = id + data[3:0] + data[7:4];
		return 4'hF - sum;
	endfunction

endpackage

FILE: rtl/core/ncfal_front.sv
`timescale 1ns / 1ps

module ncfal_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          req_type,
	input  logic [3:0]          cmd_id,
	input  logic [7:0]          cmd_value,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data,
	output logic                push,
	output ncfal_pkg::action_t  push_act
);
	import ncfal_pkg::*;

	logic       pending_q;
	logic [3:0] expected_id_q;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [7:0] attempt_count_q;
	logic [7:0] max_attempts_q;

	logic       pending_d;
	logic [3:0] expected_id_d;
	logic [7:0] held_byte_d;
	logic       held_valid_d;
	logic [7:0] attempt_count_d;
	logic [3:0] fid;
	logic [7:0] cnt_inc;

	assign fid     = held_byte_q[3:0];
	assign cnt_inc = (attempt_count_q == ATTEMPT_SAT) ? attempt_count_q : attempt_count_q + 8'd1;

	always_comb begin
		pending_d       = pending_q;
		expected_id_d   = expected_id_q;
		held_byte_d     = held_byte_q;
		held_valid_d    = held_valid_q;
		attempt_count_d = attempt_count_q;
		push            = 1'b0;
		push_act.kind   = ACT_STATUS;
		push_act.hdr    = '0;
		push_act.val    = '0;
		push_act.st     = ST_ACK;
		if (accept) begin
			case (req_t'(req_type))
				REQ_SEND: begin
					push            = 1'b1;
					push_act.kind   = ACT_SEND;
					push_act.hdr    = {check_nibble(cmd_id, cmd_value), cmd_id};
					push_act.val    = cmd_value;
					pending_d       = 1'b1;
					expected_id_d   = cmd_id;
					held_byte_d     = '0;
					held_valid_d    = 1'b0;
					attempt_count_d = '0;
				end
				REQ_BYTE: begin
					if (pending_q) begin
						if (!held_valid_q) begin
							held_byte_d  = rx_byte;
							held_valid_d = 1'b1;
						end else if (held_byte_q[7:4] != check_nibble(fid, rx_byte)) begin
							// bad window: drop older byte, slide by one
							held_byte_d = rx_byte;
						end else begin
							held_byte_d  = '0;
							held_valid_d = 1'b0;
							if (rx_byte == {4'd0, expected_id_q} &&
							    (fid == FID_ACK || fid == FID_UNKNOWN)) begin
								push        = 1'b1;
								push_act.st = (fid == FID_ACK) ? ST_ACK : ST_REJ;
								pending_d   = 1'b0;
							end
						end
					end
				end
				REQ_TICK: begin
					if (pending_q) begin
						attempt_count_d = cnt_inc;
						if (cnt_inc >= max_attempts_q) begin
							push         = 1'b1;
							push_act.st  = ST_TIMEOUT;
							pending_d    = 1'b0;
							held_byte_d  = '0;
							held_valid_d = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q       <= 1'b0;
			expected_id_q   <= '0;
			held_byte_q     <= '0;
			held_valid_q    <= 1'b0;
			attempt_count_q <= '0;
			max_attempts_q  <= MAX_ATTEMPTS_RST;
		end else begin
			pending_q       <= pending_d;
			expected_id_q   <= expected_id_d;
			held_byte_q     <= held_byte_d;
			held_valid_q    <= held_valid_d;
			attempt_count_q <= attempt_count_d;
			if (cfg_we) begin
				max_attempts_q <= cfg_data;
			end
		end
	end

endmodule

FILE: rtl/core/ncfal_queue.sv
`timescale 1ns / 1ps

module ncfal_queue #(
	parameter int DEPTH = ncfal_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ncfal_pkg::action_t  push_act,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output ncfal_pkg::action_t  head
);
	import ncfal_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	action_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/ncfal_back.sv
`timescale 1ns / 1ps

module ncfal_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  ncfal_pkg::action_t  head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_kind,
	output logic [7:0]          tx_byte,
	output logic [1:0]          status,
	output logic                last
);
	import ncfal_pkg::*;

	logic beat_q;      // second byte of a send is next
	logic load;

	assign load = !empty && (!out_valid || out_ready);
	assign pop  = load && (head.kind == ACT_STATUS || beat_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			beat_q    <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
			beat_q    <= (head.kind == ACT_SEND) && !beat_q;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (head.kind == ACT_STATUS) begin
				out_kind <= KIND_STATUS;
				tx_byte  <= '0;
				status   <= head.st;
				last     <= 1'b1;
			end else begin
				out_kind <= KIND_TX;
				tx_byte  <= beat_q ? head.val : head.hdr;
				status   <= ST_ACK;
				last     <= beat_q;
			end
		end
	end

endmodule

FILE: rtl/core/nibble_check_frame_ack_link_unit.sv
// Host side of a two-byte command link with a nibble check.
// Input channel (in_valid/in_ready): req_type selects send command, received
// byte or receive-attempt tick; cmd_id/cmd_value/rx_byte carry the payload.
// Output channel (out_valid/out_ready): one result per transaction, either a
// transmit byte (out_kind 0) or a completion status (out_kind 1); last marks
// the final result caused by an input transaction. A send gives two results
// (header, then value); ack, reject or timeout give one.
// cfg_we/cfg_data write max_attempts (reset value 20); write only when idle.
// The first result of an input transaction passes the action queue and then
// the output register. Throughput: one input transaction per cycle while the
// action queue has room; the output register emits one result per cycle while
// out_ready is high, so each send in a run needs a header and a value beat.
// Reset clears the link state, empties the queue and drops out_valid.
// While out_ready is low the output holds; work gathers in the queue and
// in_ready falls once the queue is full.
`timescale 1ns / 1ps

module nibble_check_frame_ack_link_unit #(
	parameter int QUEUE_DEPTH = ncfal_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [3:0] cmd_id,
	input  logic [7:0] cmd_value,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] tx_byte,
	output logic [1:0] status,
	output logic       last,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);
	import ncfal_pkg::*;

	logic    accept;
	logic    push;
	logic    pop;
	logic    full;
	logic    empty;
	action_t push_act;
	action_t head;

	// front end may only take a transaction when its action has a slot
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// front: deframing window, wait state, attempt counter
	ncfal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.cmd_id    (cmd_id),
		.cmd_value (cmd_value),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_act  (push_act)
	);

	// decouples front from output stalls
	ncfal_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_act (push_act),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	// back: expands actions into results through the output register
	ncfal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.tx_byte   (tx_byte),
		.status    (status),
		.last      (last)
	);

endmodule

FILE: rtl/core/ncfal_checker.sv
`timescale 1ns / 1ps

module ncfal_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_kind,
	input logic [7:0] tx_byte,
	input logic [1:0] status,
	input logic       last
);
	import ncfal_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
		else $error("result changed while stalled");

	// a completion is always the single result of its transaction
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STATUS |-> last && tx_byte == 8'd0)
		else $error("malformed status result");

	// a header byte is always followed by its value byte
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind == KIND_TX && !last
		|=> out_valid && out_kind == KIND_TX && last)
		else $error("send frame split");

	a_tx_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_TX |-> status == ST_ACK)
		else $error("status set on transmit byte");

endmodule

bind nibble_check_frame_ack_link_unit ncfal_checker u_ncfal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_kind  (out_kind),
	.tx_byte   (tx_byte),
	.status    (status),
	.last      (last)
);
